// ===== design/a64e_pkg.sv =====
// ----------------------------------------------------------------------------
// a64e_pkg
// Types and fixed encodings shared by the A64 instruction encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package a64e_pkg;

  typedef enum logic [4:0] {
    CMD_NOP    = 5'd0,
    CMD_BRK    = 5'd1,
    CMD_LDR    = 5'd2,
    CMD_STR    = 5'd3,
    CMD_LDP    = 5'd4,
    CMD_STP    = 5'd5,
    CMD_BLR    = 5'd6,
    CMD_B      = 5'd7,
    CMD_BCOND  = 5'd8,
    CMD_ADD    = 5'd9,
    CMD_SUB    = 5'd10,
    CMD_RET    = 5'd11,
    CMD_MOVZ   = 5'd12,
    CMD_MOVK   = 5'd13,
    CMD_MOVN   = 5'd14,
    CMD_ADDIMM = 5'd15,
    CMD_SUBIMM = 5'd16,
    CMD_CMPIMM = 5'd17,
    CMD_AND    = 5'd18,
    CMD_ORR    = 5'd19,
    CMD_EOR    = 5'd20,
    CMD_LSL    = 5'd21,
    CMD_LSR    = 5'd22,
    CMD_ASR    = 5'd23,
    CMD_MUL    = 5'd24,
    CMD_UDIV   = 5'd25,
    CMD_SDIV   = 5'd26
  } a64e_cmd_t;

  localparam int unsigned OFFSET_W   = 25;
  localparam int unsigned POSITION_W = 24;

  localparam logic [OFFSET_W-1:0] CAPACITY_RESET = 25'd65536;
  localparam logic [OFFSET_W-1:0] WORD_BYTES     = 25'd4;

  localparam logic [31:0] ENC_NOP       = 32'hD503201F;
  localparam logic [31:0] ENC_BRK       = 32'hD4200000;
  localparam logic [31:0] ENC_LDST_X    = 32'hF9000000;
  localparam logic [31:0] ENC_LDST_W    = 32'hB9000000;
  localparam logic [31:0] ENC_LDSTU_X   = 32'hF8000000;
  localparam logic [31:0] ENC_LDSTU_W   = 32'hB8000000;
  localparam logic [31:0] ENC_LOAD_BIT  = 32'h00400000;
  localparam logic [31:0] ENC_LDP       = 32'hA9400000;
  localparam logic [31:0] ENC_STP       = 32'hA9000000;
  localparam logic [31:0] ENC_BLR       = 32'hD63F0000;
  localparam logic [31:0] ENC_RET       = 32'hD65F0000;
  localparam logic [31:0] ENC_B         = 32'h14000000;
  localparam logic [31:0] ENC_BCOND     = 32'h54000000;
  localparam logic [31:0] ENC_ADD_X     = 32'h8B000000;
  localparam logic [31:0] ENC_ADD_W     = 32'h0B000000;
  localparam logic [31:0] ENC_SUB_X     = 32'hCB000000;
  localparam logic [31:0] ENC_SUB_W     = 32'h4B000000;
  localparam logic [31:0] ENC_MUL_X     = 32'h9B000000;
  localparam logic [31:0] ENC_MUL_W     = 32'h1B000000;
  localparam logic [31:0] ENC_UDIV_X    = 32'h9AC00800;
  localparam logic [31:0] ENC_UDIV_W    = 32'h1AC00800;
  localparam logic [31:0] ENC_SDIV_X    = 32'h9AC00C00;
  localparam logic [31:0] ENC_SDIV_W    = 32'h1AC00C00;
  localparam logic [5:0]  ENC_MOVWIDE   = 6'b100101;
  localparam logic [5:0]  ENC_ADDSUBIMM = 6'b100010;
  localparam logic [4:0]  ENC_LOGICAL   = 5'b01010;
  localparam logic [5:0]  ENC_BITFIELD  = 6'b100110;
  localparam logic [4:0]  REG_ZR        = 5'd31;

  typedef struct packed {
    logic [4:0]         command;
    logic [4:0]         reg_a;
    logic [4:0]         reg_b;
    logic [4:0]         reg_c;
    logic signed [31:0] byte_offset_operand;
    logic [31:0]        imm;
    logic [7:0]         half_select;
    logic [7:0]         access_size;
    logic               wide;
    logic               update_flags;
    logic [3:0]         cond_code;
  } a64e_req_t;

  typedef struct packed {
    logic [31:0]           encoded_word;
    logic [POSITION_W-1:0] word_position;
    logic                  written;
    logic                  encoding_error_flag;
    logic                  overflow_flag;
  } a64e_rsp_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] buffer_capacity;
  } a64e_cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic        ok;
  } a64e_work_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] write_offset;
    logic                err_seen;
    logic                ovf_seen;
  } a64e_stat_t;

endpackage

`default_nettype wire

// ===== design/a64e_chan_if.sv =====
// ----------------------------------------------------------------------------
// a64e_chan_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none

interface a64e_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== design/a64e_queue.sv =====
// ----------------------------------------------------------------------------
// a64e_queue
// Small FIFO between the encoding front and the commit back end.
// ----------------------------------------------------------------------------
`default_nettype none

module a64e_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire a64e_pkg::a64e_work_t push_data,
  output logic                     full,
  input  wire logic                pop,
  output a64e_pkg::a64e_work_t     pop_data,
  output logic                     not_empty
);
  import a64e_pkg::*;

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

  a64e_work_t         entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full      = (count == DEPTH_CNT);
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/a64e_front.sv =====
// ----------------------------------------------------------------------------
// a64e_front
// Accept a request, check its operands and pack the instruction word.
// ----------------------------------------------------------------------------
`default_nettype none

module a64e_front (
  a64e_chan_if.sink            req,
  input  wire logic            q_full,
  output logic                 push,
  output a64e_pkg::a64e_work_t push_data
);
  import a64e_pkg::*;

  logic               sf;
  logic [4:0]         ra;
  logic [4:0]         rb;
  logic [4:0]         rc;
  logic signed [31:0] off;
  logic [31:0]        imm;
  logic [7:0]         hw;
  logic               is64;
  logic               size_ok;
  logic               scaled_ok;
  logic [11:0]        imm12;
  logic               unscaled_ok;
  logic               imm16_ok;
  logic               imm12_ok;
  logic [5:0]         top;
  logic [5:0]         amt;
  logic [5:0]         immr;
  logic [5:0]         imms;
  logic [1:0]         opc;
  logic [31:0]        base;
  logic [31:0]        rm_rn_rd;
  logic [31:0]        word;
  logic               ok;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_comb begin
    sf   = req.data.wide;
    ra   = req.data.reg_a;
    rb   = req.data.reg_b;
    rc   = req.data.reg_c;
    off  = req.data.byte_offset_operand;
    imm  = req.data.imm;
    hw   = req.data.half_select;

    is64        = (req.data.access_size == 8'd8);
    size_ok     = is64 || (req.data.access_size == 8'd4);
    scaled_ok   = !off[31] && (is64 ? (off[2:0] == 3'd0 && off[31:15] == '0)
                                    : (off[1:0] == 2'd0 && off[31:14] == '0));
    imm12       = is64 ? off[14:3] : off[13:2];
    unscaled_ok = (&off[31:8]) || (off[31:8] == '0);
    imm16_ok    = (imm[31:16] == '0);
    imm12_ok    = (imm[31:12] == '0);
    top         = sf ? 6'd63 : 6'd31;
    amt         = imm[5:0];
    rm_rn_rd    = {11'd0, rc, 6'd0, rb, ra};

    word = '0;
    ok   = 1'b0;
    base = '0;
    opc  = '0;
    immr = '0;
    imms = '0;

    case (req.data.command)
      CMD_NOP: begin
        word = ENC_NOP;
        ok   = 1'b1;
      end
      CMD_BRK: begin
        word = ENC_BRK | {11'd0, imm[15:0], 5'd0};
        ok   = imm16_ok;
      end
      CMD_LDR, CMD_STR: begin
        ok = (ra != REG_ZR) && size_ok && (scaled_ok || unscaled_ok);
        if (scaled_ok) begin
          base = is64 ? ENC_LDST_X : ENC_LDST_W;
          word = base | {10'd0, imm12, rb, ra};
        end else begin
          base = is64 ? ENC_LDSTU_X : ENC_LDSTU_W;
          word = base | {11'd0, off[8:0], 2'd0, rb, ra};
        end
        if (req.data.command == CMD_LDR) begin
          word = word | ENC_LOAD_BIT;
        end
      end
      CMD_LDP, CMD_STP: begin
        ok   = (ra != REG_ZR) && (rc != REG_ZR) && (off[2:0] == 3'd0)
               && ((&off[31:9]) || (off[31:9] == '0));
        base = (req.data.command == CMD_LDP) ? ENC_LDP : ENC_STP;
        word = base | {10'd0, off[9:3], rc, rb, ra};
      end
      CMD_BLR, CMD_RET: begin
        ok   = (rb != REG_ZR);
        base = (req.data.command == CMD_BLR) ? ENC_BLR : ENC_RET;
        word = base | {22'd0, rb, 5'd0};
      end
      CMD_B: begin
        ok   = (off[1:0] == 2'd0) && ((&off[31:27]) || (off[31:27] == '0));
        word = ENC_B | {6'd0, off[27:2]};
      end
      CMD_BCOND: begin
        ok   = (off[1:0] == 2'd0) && ((&off[31:20]) || (off[31:20] == '0));
        word = ENC_BCOND | {8'd0, off[20:2], 1'b0, req.data.cond_code};
      end
      CMD_ADD: begin
        ok   = 1'b1;
        word = (sf ? ENC_ADD_X : ENC_ADD_W) | rm_rn_rd;
      end
      CMD_SUB: begin
        ok   = 1'b1;
        word = (sf ? ENC_SUB_X : ENC_SUB_W) | rm_rn_rd;
      end
      CMD_MOVZ, CMD_MOVK, CMD_MOVN: begin
        opc  = (req.data.command == CMD_MOVZ) ? 2'd2 :
               (req.data.command == CMD_MOVK) ? 2'd3 : 2'd0;
        ok   = imm16_ok && (hw[7:2] == '0) && (sf || !hw[1]);
        word = {sf, opc, ENC_MOVWIDE, hw[1:0], imm[15:0], ra};
      end
      CMD_ADDIMM, CMD_SUBIMM: begin
        ok   = imm12_ok;
        word = {sf, (req.data.command == CMD_SUBIMM), req.data.update_flags,
                ENC_ADDSUBIMM, 1'b0, imm[11:0], rb, ra};
      end
      CMD_CMPIMM: begin
        ok   = imm12_ok;
        word = {sf, 1'b1, 1'b1, ENC_ADDSUBIMM, 1'b0, imm[11:0], rb, REG_ZR};
      end
      CMD_AND, CMD_ORR, CMD_EOR: begin
        opc  = (req.data.command == CMD_AND) ? 2'd0 :
               (req.data.command == CMD_ORR) ? 2'd1 : 2'd2;
        ok   = 1'b1;
        word = {sf, opc, ENC_LOGICAL, 24'd0} | rm_rn_rd;
      end
      CMD_LSL, CMD_LSR, CMD_ASR: begin
        ok  = (imm[31:6] == '0) && (sf || !imm[5]);
        opc = (req.data.command == CMD_ASR) ? 2'd0 : 2'd2;
        if (req.data.command == CMD_LSL) begin
          immr = (6'd0 - amt) & top;
          imms = top - amt;
        end else begin
          immr = amt;
          imms = top;
        end
        word = {sf, opc, ENC_BITFIELD, sf, immr, imms, rb, ra};
      end
      CMD_MUL: begin
        ok   = 1'b1;
        word = (sf ? ENC_MUL_X : ENC_MUL_W) | {11'd0, rc, 1'b0, REG_ZR, rb, ra};
      end
      CMD_UDIV: begin
        ok   = 1'b1;
        word = (sf ? ENC_UDIV_X : ENC_UDIV_W) | rm_rn_rd;
      end
      CMD_SDIV: begin
        ok   = 1'b1;
        word = (sf ? ENC_SDIV_X : ENC_SDIV_W) | rm_rn_rd;
      end
      default: begin
        ok   = 1'b0;
        word = '0;
      end
    endcase

    push_data.ok   = ok;
    push_data.word = ok ? word : '0;
  end

endmodule

`default_nettype wire

// ===== design/a64e_back.sv =====
// ----------------------------------------------------------------------------
// a64e_back
// Commit encoded words: check capacity, advance the offset, keep flags.
// ----------------------------------------------------------------------------
`default_nettype none

module a64e_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_not_empty,
  input  wire a64e_pkg::a64e_work_t q_data,
  output logic                      pop,
  a64e_chan_if.source               rsp,
  a64e_chan_if.sink                 cfg,
  output a64e_pkg::a64e_stat_t      stat
);
  import a64e_pkg::*;

  logic [OFFSET_W-1:0] capacity;
  logic [OFFSET_W-1:0] write_offset;
  logic [OFFSET_W-1:0] write_offset_next;
  logic                err_seen;
  logic                err_seen_next;
  logic                ovf_seen;
  logic                ovf_seen_next;
  logic                fits;
  logic                commit;
  logic                rsp_valid;
  a64e_rsp_t           rsp_data;

  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign pop  = q_not_empty && (!rsp_valid || rsp.ready);
  assign fits = ({1'b0, write_offset} + {1'b0, WORD_BYTES}) <= {1'b0, capacity};

  always_comb begin
    commit            = q_data.ok && fits;
    write_offset_next = commit ? write_offset + WORD_BYTES : write_offset;
    err_seen_next     = err_seen || !q_data.ok;
    ovf_seen_next     = ovf_seen || (q_data.ok && !fits);
  end

  assign stat.write_offset = write_offset;
  assign stat.err_seen     = err_seen;
  assign stat.ovf_seen     = ovf_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAPACITY_RESET;
      write_offset <= '0;
      err_seen     <= 1'b0;
      ovf_seen     <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.data.buffer_capacity;
      end
      if (pop) begin
        write_offset <= write_offset_next;
        err_seen     <= err_seen_next;
        ovf_seen     <= ovf_seen_next;
        rsp_valid    <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp_data.encoded_word        <= q_data.word;
      rsp_data.word_position       <= write_offset[POSITION_W-1:0];
      rsp_data.written             <= commit;
      rsp_data.encoding_error_flag <= err_seen_next;
      rsp_data.overflow_flag       <= ovf_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/a64_instruction_encoder.sv =====
// ----------------------------------------------------------------------------
// a64_instruction_encoder
// Packs A64 instruction words from command requests and places them in a
// code buffer by offset, with sticky encoding-error and overflow flags.
// ----------------------------------------------------------------------------
//   channel  dir  payload      handshake
//   req      in   a64e_req_t   valid/ready
//   rsp      out  a64e_rsp_t   valid/ready
//   cfg      in   a64e_cfg_t   valid/ready (ready always high)
//
// One request per cycle sustained while rsp is ready; a request is encoded
// into the queue, then committed into the output register.
// The loop-carried state is the write offset, updated at commit, and the sticky flags.
// Reset: offset and flags clear, capacity returns to 65536 bytes.
// A stalled result fills the queue; req.ready drops once it holds
// QUEUE_DEPTH words.
// ----------------------------------------------------------------------------
`default_nettype none

module a64_instruction_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  a64e_chan_if.sink   req,
  a64e_chan_if.source rsp,
  a64e_chan_if.sink   cfg
);
  import a64e_pkg::*;

  logic       q_push;
  a64e_work_t q_push_data;
  logic       q_full;
  logic       q_pop;
  a64e_work_t q_pop_data;
  logic       q_not_empty;
  a64e_stat_t stat;

  a64e_front u_front (
    .req       (req),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  a64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  a64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_pop_data),
    .pop         (q_pop),
    .rsp         (rsp),
    .cfg         (cfg),
    .stat        (stat)
  );

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    stat.err_seen |=> stat.err_seen)
    else $error("encoding error flag cleared");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    stat.ovf_seen |=> stat.ovf_seen)
    else $error("overflow flag cleared");

  a_offset_aligned: assert property (@(posedge clk) disable iff (rst)
    stat.write_offset[1:0] == 2'd0)
    else $error("write offset not word aligned");

  a_written_advance: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.written |->
      stat.write_offset == ({1'b0, rsp.data.word_position} + WORD_BYTES))
    else $error("offset does not match last written word");

endmodule

`default_nettype wire

// ===== dv/a64e_checker.sv =====
// ----------------------------------------------------------------------------
// a64e_checker
// Passive scoreboard for the A64 instruction encoder. Tracks capacity writes,
// predicts the result of every accepted request from its own copy of the
// write offset and sticky flags, and compares each accepted result, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module a64e_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  a64e_pkg::a64e_req_t req_data,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  a64e_pkg::a64e_rsp_t rsp_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  a64e_pkg::a64e_cfg_t cfg_data,
  output int                  bad_words,
  output int                  open_words
);
  import a64e_pkg::*;

  logic [OFFSET_W-1:0] capacity;
  logic [OFFSET_W-1:0] next_offset;
  logic                err_sticky;
  logic                ovf_sticky;
  a64e_rsp_t           placement_q[$];

  function automatic bit fits(longint v, int n);
    longint lim;
    lim = longint'(1) << (n - 1);
    return (v >= -lim) && (v <= lim - 1);
  endfunction

  function automatic logic [31:0] field(longint v, int n);
    return 32'(v & ((longint'(1) << n) - 1));
  endfunction

  function automatic bit pack_insn(input a64e_req_t r, output logic [31:0] w);
    longint      off;
    longint      sz;
    logic [31:0] base;
    logic [31:0] regs;
    logic [5:0]  top;
    logic [5:0]  amt;
    logic [5:0]  immr;
    logic [5:0]  imms;
    logic [1:0]  opc;
    logic        sb;
    logic [4:0]  rd;
    off  = longint'($signed(r.byte_offset_operand));
    sz   = longint'(r.access_size);
    regs = {11'b0, r.reg_c, 6'b0, r.reg_b, r.reg_a};
    w    = '0;
    case (r.command)
      CMD_NOP: w = ENC_NOP;
      CMD_BRK: begin
        if (r.imm > 32'hFFFF) return 1'b0;
        w = ENC_BRK | {11'b0, r.imm[15:0], 5'b0};
      end
      CMD_LDR, CMD_STR: begin
        if (r.reg_a == REG_ZR) return 1'b0;
        if (sz != 8 && sz != 4) return 1'b0;
        if (off >= 0 && off % sz == 0 && off / sz <= 4095) begin
          base = (sz == 8) ? ENC_LDST_X : ENC_LDST_W;
          if (r.command == CMD_LDR) base |= ENC_LOAD_BIT;
          w = base | (field(off / sz, 12) << 10) | {22'b0, r.reg_b, r.reg_a};
        end else if (fits(off, 9)) begin
          base = (sz == 8) ? ENC_LDSTU_X : ENC_LDSTU_W;
          if (r.command == CMD_LDR) base |= ENC_LOAD_BIT;
          w = base | (field(off, 9) << 12) | {22'b0, r.reg_b, r.reg_a};
        end else begin
          return 1'b0;
        end
      end
      CMD_LDP, CMD_STP: begin
        if (r.reg_a == REG_ZR || r.reg_c == REG_ZR) return 1'b0;
        if (off % 8 != 0 || !fits(off / 8, 7)) return 1'b0;
        base = (r.command == CMD_LDP) ? ENC_LDP : ENC_STP;
        w = base | (field(off / 8, 7) << 15) | {17'b0, r.reg_c, r.reg_b, r.reg_a};
      end
      CMD_BLR, CMD_RET: begin
        if (r.reg_b == REG_ZR) return 1'b0;
        w = ((r.command == CMD_BLR) ? ENC_BLR : ENC_RET) | {22'b0, r.reg_b, 5'b0};
      end
      CMD_B: begin
        if (off % 4 != 0 || !fits(off / 4, 26)) return 1'b0;
        w = ENC_B | field(off / 4, 26);
      end
      CMD_BCOND: begin
        if (off % 4 != 0 || !fits(off / 4, 19)) return 1'b0;
        w = ENC_BCOND | (field(off / 4, 19) << 5) | {28'b0, r.cond_code};
      end
      CMD_ADD: w = (r.wide ? ENC_ADD_X : ENC_ADD_W) | regs;
      CMD_SUB: w = (r.wide ? ENC_SUB_X : ENC_SUB_W) | regs;
      CMD_MOVZ, CMD_MOVK, CMD_MOVN: begin
        opc = (r.command == CMD_MOVZ) ? 2'd2 : ((r.command == CMD_MOVK) ? 2'd3 : 2'd0);
        if (r.imm > 32'hFFFF || r.half_select > 8'd3) return 1'b0;
        if (!r.wide && r.half_select > 8'd1) return 1'b0;
        w = {r.wide, opc, ENC_MOVWIDE, r.half_select[1:0], r.imm[15:0], r.reg_a};
      end
      CMD_ADDIMM, CMD_SUBIMM, CMD_CMPIMM: begin
        if (r.imm > 32'd4095) return 1'b0;
        rd = (r.command == CMD_CMPIMM) ? REG_ZR : r.reg_a;
        sb = (r.command == CMD_CMPIMM) ? 1'b1 : r.update_flags;
        w = {r.wide, r.command != CMD_ADDIMM, sb, ENC_ADDSUBIMM, 1'b0, r.imm[11:0],
             r.reg_b, rd};
      end
      CMD_AND, CMD_ORR, CMD_EOR: begin
        opc = 2'(r.command - CMD_AND);
        w = {r.wide, opc, ENC_LOGICAL, 24'b0} | regs;
      end
      CMD_LSL, CMD_LSR, CMD_ASR: begin
        top = r.wide ? 6'd63 : 6'd31;
        if (r.imm > 32'(top)) return 1'b0;
        amt = r.imm[5:0];
        if (r.command == CMD_LSL) begin
          immr = 6'((int'(top) + 1 - int'(amt)) & int'(top));
          imms = top - amt;
        end else begin
          immr = amt;
          imms = top;
        end
        opc = (r.command == CMD_ASR) ? 2'd0 : 2'd2;
        w = {r.wide, opc, ENC_BITFIELD, r.wide, immr, imms, r.reg_b, r.reg_a};
      end
      CMD_MUL:  w = (r.wide ? ENC_MUL_X : ENC_MUL_W) | {17'b0, REG_ZR, 10'b0} | regs;
      CMD_UDIV: w = (r.wide ? ENC_UDIV_X : ENC_UDIV_W) | regs;
      CMD_SDIV: w = (r.wide ? ENC_SDIV_X : ENC_SDIV_W) | regs;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic a64e_rsp_t place_word(input a64e_req_t r);
    a64e_rsp_t   o;
    logic [31:0] w;
    o = '0;
    o.word_position = next_offset[POSITION_W-1:0];
    if (!pack_insn(r, w)) begin
      err_sticky = 1'b1;
      w = '0;
    end else if ({1'b0, next_offset} + 26'd4 > {1'b0, capacity}) begin
      ovf_sticky = 1'b1;
    end else begin
      next_offset = next_offset + WORD_BYTES;
      o.written = 1'b1;
    end
    o.encoded_word        = w;
    o.encoding_error_flag = err_sticky;
    o.overflow_flag       = ovf_sticky;
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad_words++;
    end
  endtask

  always @(posedge clk) begin
    a64e_rsp_t e;
    if (rst) begin
      capacity    = CAPACITY_RESET;
      next_offset = '0;
      err_sticky  = 1'b0;
      ovf_sticky  = 1'b0;
      placement_q.delete();
      bad_words   = 0;
      open_words <= 0;
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data.buffer_capacity;
      if (rsp_valid && rsp_ready) begin
        if (placement_q.size() == 0) begin
          $error("result word %0h with nothing outstanding", rsp_data.encoded_word);
          bad_words++;
        end else begin
          e = placement_q.pop_front();
          check_field("encoded_word", e.encoded_word, rsp_data.encoded_word);
          check_field("word_position", 32'(e.word_position), 32'(rsp_data.word_position));
          check_field("written", 32'(e.written), 32'(rsp_data.written));
          check_field("encoding_error_flag", 32'(e.encoding_error_flag),
                      32'(rsp_data.encoding_error_flag));
          check_field("overflow_flag", 32'(e.overflow_flag), 32'(rsp_data.overflow_flag));
        end
      end
      if (req_valid && req_ready) placement_q.push_back(place_word(req_data));
      open_words <= placement_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the A64 instruction encoder. Drives a directed
// sweep over every command and its edge cases, then random request phases
// under different capacities and idle/stall mixes; the checker scores every
// result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import a64e_pkg::*;

  localparam logic [4:0] CMD_UNUSED = 5'd31;

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   sink_hold;
  int   bad_words;
  int   open_words;

  a64e_chan_if #(.payload_t(a64e_req_t)) req_if ();
  a64e_chan_if #(.payload_t(a64e_rsp_t)) rsp_if ();
  a64e_chan_if #(.payload_t(a64e_cfg_t)) cfg_if ();

  a64_instruction_encoder dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  a64e_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_if.valid),
    .req_ready  (req_if.ready),
    .req_data   (req_if.data),
    .rsp_valid  (rsp_if.valid),
    .rsp_ready  (rsp_if.ready),
    .rsp_data   (rsp_if.data),
    .cfg_valid  (cfg_if.valid),
    .cfg_ready  (cfg_if.ready),
    .cfg_data   (cfg_if.data),
    .bad_words  (bad_words),
    .open_words (open_words)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        rsp_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic a64e_req_t mk(logic [4:0] cmd, logic [4:0] ra, logic [4:0] rb,
                                   logic [4:0] rc, logic [31:0] off, logic [31:0] imm,
                                   logic [7:0] hw, logic [7:0] size, logic wide,
                                   logic s, logic [3:0] cond);
    a64e_req_t r;
    r.command             = cmd;
    r.reg_a               = ra;
    r.reg_b               = rb;
    r.reg_c               = rc;
    r.byte_offset_operand = off;
    r.imm                 = imm;
    r.half_select         = hw;
    r.access_size         = size;
    r.wide                = wide;
    r.update_flags        = s;
    r.cond_code           = cond;
    return r;
  endfunction

  function automatic logic [4:0] rand_reg();
    return ($urandom_range(7) == 0) ? REG_ZR : 5'($urandom_range(31));
  endfunction

  function automatic logic [31:0] rand_offset(logic [7:0] size);
    int edges[20] = '{0, -1, 255, 256, -256, -257, 504, 512, -512, 32760, 16380,
                      134217724, -134217728, 134217728, 1048572, -1048576, 1048576,
                      32'h7FFFFFFF, 32'h80000000, 16384};
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'(int'($urandom_range(511)) - 256);
      2: return 32'($urandom_range(32'h0FFFFFFF)) & 32'hFFFFFFFC;
      3: return 32'((int'($urandom_range(127)) - 64) * 8);
      4: return 32'($urandom_range(4095)) * 32'(size);
      5: return 32'((int'($urandom_range(524287)) - 262144) * 4);
      6: return 32'(edges[$urandom_range(19)]);
      default: return 32'(int'($urandom_range(128)) - 64);
    endcase
  endfunction

  function automatic logic [31:0] rand_imm();
    logic [31:0] edges[10] = '{0, 31, 32, 63, 64, 4095, 4096, 65535, 65536, 32'hFFFFFFFF};
    case ($urandom_range(5))
      0: return $urandom_range(65535);
      1: return $urandom_range(4095);
      2: return $urandom_range(63);
      3: return $urandom;
      default: return edges[$urandom_range(9)];
    endcase
  endfunction

  function automatic a64e_req_t rand_req();
    a64e_req_t r;
    r.command = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 27))
                                          : 5'($urandom_range(26));
    r.reg_a       = rand_reg();
    r.reg_b       = rand_reg();
    r.reg_c       = rand_reg();
    r.access_size = ($urandom_range(5) == 0) ? 8'($urandom)
                                             : ($urandom_range(1) ? 8'd8 : 8'd4);
    r.byte_offset_operand = rand_offset(r.access_size);
    r.imm         = rand_imm();
    r.half_select = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    r.wide        = 1'($urandom_range(1));
    r.update_flags = 1'($urandom_range(1));
    r.cond_code   = 4'($urandom_range(15));
    return r;
  endfunction

  task automatic put_req(input a64e_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic req_stop();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  task automatic write_capacity(input logic [OFFSET_W-1:0] cap);
    @(negedge clk);
    cfg_if.valid                <= 1'b1;
    cfg_if.data.buffer_capacity <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [OFFSET_W-1:0] cap;
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_hold      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    put_req(mk(CMD_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    put_req(mk(CMD_BRK, 31, 31, 31, 32'hFFFFFFFF, 32'hFFFF, 8'hFF, 8'hFF, 1, 1, 4'hF));
    put_req(mk(CMD_BRK, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 0));
    put_req(mk(CMD_LDR, 30, 31, 0, 32760, 0, 0, 8, 1, 0, 0));
    put_req(mk(CMD_STR, 0, 5, 0, -256, 0, 0, 4, 0, 0, 0));
    put_req(mk(CMD_LDR, 1, 2, 0, 16384, 0, 0, 4, 0, 0, 0));
    put_req(mk(CMD_STR, 31, 2, 0, 8, 0, 0, 8, 0, 0, 0));
    put_req(mk(CMD_LDR, 3, 4, 0, 0, 0, 0, 5, 0, 0, 0));
    put_req(mk(CMD_LDP, 0, 31, 30, -512, 0, 0, 0, 1, 0, 0));
    put_req(mk(CMD_STP, 1, 2, 31, 504, 0, 0, 0, 1, 0, 0));
    put_req(mk(CMD_BLR, 0, 30, 0, 0, 0, 0, 0, 0, 0, 0));
    put_req(mk(CMD_RET, 0, 31, 0, 0, 0, 0, 0, 0, 0, 0));
    put_req(mk(CMD_B, 0, 0, 0, 32'hF8000000, 0, 0, 0, 0, 0, 0));
    put_req(mk(CMD_BCOND, 0, 0, 0, 1048572, 0, 0, 0, 0, 0, 4'hF));
    put_req(mk(CMD_ADD, 31, 31, 31, 0, 0, 0, 0, 1, 0, 0));
    put_req(mk(CMD_SUB, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    put_req(mk(CMD_MOVZ, 31, 0, 0, 0, 32'hFFFF, 3, 0, 1, 0, 0));
    put_req(mk(CMD_MOVK, 4, 0, 0, 0, 1, 2, 0, 0, 0, 0));
    put_req(mk(CMD_MOVN, 7, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    put_req(mk(CMD_ADDIMM, 1, 2, 0, 0, 4095, 0, 0, 1, 1, 0));
    put_req(mk(CMD_SUBIMM, 1, 2, 0, 0, 4096, 0, 0, 0, 0, 0));
    put_req(mk(CMD_CMPIMM, 5, 6, 0, 0, 7, 0, 0, 1, 0, 0));
    put_req(mk(CMD_AND, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0));
    put_req(mk(CMD_ORR, 4, 5, 6, 0, 0, 0, 0, 1, 0, 0));
    put_req(mk(CMD_EOR, 31, 31, 31, 0, 0, 0, 0, 1, 0, 0));
    put_req(mk(CMD_LSL, 1, 2, 0, 0, 0, 0, 0, 1, 0, 0));
    put_req(mk(CMD_LSR, 3, 4, 0, 0, 31, 0, 0, 0, 0, 0));
    put_req(mk(CMD_ASR, 5, 6, 0, 0, 64, 0, 0, 1, 0, 0));
    put_req(mk(CMD_MUL, 7, 8, 9, 0, 0, 0, 0, 1, 0, 0));
    put_req(mk(CMD_UDIV, 10, 11, 12, 0, 0, 0, 0, 0, 0, 0));
    put_req(mk(CMD_SDIV, 13, 14, 15, 0, 0, 0, 0, 1, 0, 0));
    put_req(mk(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    req_stop();
    wait (open_words == 0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          cap            = 25'd16777216;
        end
        1: begin
          src_idle_pct   = 69;
          sink_stall_pct = 0;
          cap            = 25'($urandom_range(4000, 1000));
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 69;
          cap            = '0;
        end
        default: begin
          src_idle_pct   = 6;
          sink_stall_pct = 6;
          cap            = 25'($urandom_range(16777216));
        end
      endcase
      write_capacity(cap);
      for (int i = 0; i < 500; i++) begin
        // hold the result side off long enough to back up the input
        if (p == 0 && i == 60) sink_hold = 120;
        put_req(rand_req());
      end
      req_stop();
      wait (open_words == 0);
    end

    repeat (8) @(posedge clk);
    if (bad_words == 0 && open_words == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/a64e_pkg.sv
design/a64e_chan_if.sv
design/a64e_queue.sv
design/a64e_front.sv
design/a64e_back.sv
design/a64_instruction_encoder.sv
dv/a64e_checker.sv
dv/tb_top.sv
